/* design/sdfs_pkg.sv */
// Shared types, constants and handshake structs for the safety-distance block.
// No dependencies; compiled first.
package sdfs_pkg;

  localparam int SPEED_W        = 16;
  localparam int DIST_W         = 24;
  localparam int MAXCHG_W       = 15;
  localparam int WINDOW_DEFAULT = 10;

  // Sequential divider geometry
  localparam int DIV_W      = 32;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  // distance = BASE + floor((LIN*v + v*v) / DEN), all in Q8.8 / Q16.8
  localparam int DIST_BASE = 512;
  localparam int DIST_LIN  = 55296;
  localparam int DIST_DEN  = 51200;
  localparam int PROD_W    = 34;
  localparam int FACTOR_W  = 18;

  // DEN = 25 << DIST_SH; divide by 25 as multiply by ceil(2^RECIP_SH / 25),
  // exact for numerators below 2^RECIP_SH / 11
  localparam int MAG_W        = 32;
  localparam int DIST_SH      = 11;
  localparam int SCALED_W     = MAG_W - DIST_SH;
  localparam int RECIP        = 2684355;
  localparam int RECIP_W      = 22;
  localparam int RECIP_SH     = 26;
  localparam int RECIP_PROD_W = SCALED_W + RECIP_W;
  localparam int QUOT_W       = RECIP_PROD_W - RECIP_SH;

  localparam logic [MAXCHG_W-1:0] MAXCHG_RESET = 15'd154;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [DIST_W-1:0]  dist_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;  // magnitude, MSB-aligned
    logic [DIVISOR_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] steps;     // quotient bits to produce
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* design/sdfs_in_if.sv */
// Input channel: valid/ready handshake carrying one speed sample.
// Depends on sdfs_pkg.
interface sdfs_in_if;
  import sdfs_pkg::*;

  logic   valid;
  logic   ready;
  speed_t speed_sample;

  modport source (output valid, output speed_sample, input ready);
  modport sink   (input valid, input speed_sample, output ready);
endinterface

/* design/sdfs_out_if.sv */
// Output channel: valid/ready handshake carrying distance, filtered speed and reject flag.
// Depends on sdfs_pkg.
interface sdfs_out_if;
  import sdfs_pkg::*;

  logic   valid;
  logic   ready;
  dist_t  distance_setpoint;
  speed_t filtered_speed;
  logic   sample_rejected;

  modport source (output valid, output distance_setpoint, output filtered_speed,
                  output sample_rejected, input ready);
  modport sink   (input valid, input distance_setpoint, input filtered_speed,
                  input sample_rejected, output ready);
endinterface

/* design/sdfs_ring.sv */
// Sample ring memory with write slot, fill count and running sum (read-modify-write).
// Depends on sdfs_pkg.
module sdfs_ring #(
  parameter int WINDOW = sdfs_pkg::WINDOW_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          upd,
  input  sdfs_pkg::speed_t                              sample,
  output logic                                          done,
  output logic signed [sdfs_pkg::SPEED_W+$clog2(WINDOW)-1:0] sum,
  output logic [$clog2(WINDOW+1)-1:0]                   fill
);
  import sdfs_pkg::*;

  localparam int SUM_W  = SPEED_W + $clog2(WINDOW);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);

  speed_t              mem [WINDOW];
  speed_t              rd_data;
  speed_t              sample_q;
  logic [SLOT_W-1:0]   slot;
  logic                pend;
  logic                full;
  logic signed [SUM_W-1:0] old_val;

  // Memory: read at current slot every cycle, write the held sample while an update is pending
  always_ff @(posedge clk) begin
    if (pend) begin
      mem[slot] <= sample_q;
    end
    rd_data <= mem[slot];
  end

  // Entry being replaced counts only once the ring has wrapped; before that it reads as zero
  assign full    = (fill == FILL_W'(WINDOW));
  assign old_val = full ? SUM_W'(rd_data) : '0;

  always_ff @(posedge clk) begin
    sample_q <= upd ? sample : sample_q;
  end

  // Control: pointer, fill count, running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
      slot <= '0;
      fill <= '0;
      sum  <= '0;
    end else begin
      pend <= upd;
      done <= pend;
      if (pend) begin
        sum  <= sum - old_val + SUM_W'(sample_q);
        slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
        if (!full) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  a_upd_done: assert property (@(posedge clk) disable iff (rst) upd |-> ##2 done)
    else $error("ring update did not complete in two cycles");
  a_fill_max: assert property (@(posedge clk) disable iff (rst) fill <= FILL_W'(WINDOW))
    else $error("fill count exceeds window");

endmodule

/* design/sdfs_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on sdfs_pkg.
module sdfs_div (
  input  logic               clk,
  input  logic               rst,
  input  sdfs_pkg::div_req_t req,
  output sdfs_pkg::div_rsp_t rsp
);
  import sdfs_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor_q;
  logic [DIV_W-1:0]     quo;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   trial_sub;
  logic                 ge;

  // One restoring step
  assign trial     = {rem, quo[DIV_W-1]};
  assign ge        = (trial >= {1'b0, divisor_q});
  assign trial_sub = trial - {1'b0, divisor_q};

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo       <= req.dividend;
      rem       <= '0;
      divisor_q <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

/* design/safety_distance_from_filtered_speed.sv */
// Safety distance from a rate-checked moving-average speed.
// The average of an accepted sample comes from the bit-serial divider; a rejected sample skips
// the ring and the divider and keeps the last filtered speed.
// One sample in flight; ready returns the cycle after its result is stored, so a new sample is
// taken only once the last one is through; a held result stalls the next one.
// Reset clears control, fill count, running sum and last filtered speed; ring memory is not
// cleared, entries past the fill count are never summed. max_change resets to 154.
module safety_distance_from_filtered_speed #(
  parameter int WINDOW = sdfs_pkg::WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  sdfs_in_if.sink                       speed,
  sdfs_out_if.source                    result,
  input  logic                          cfg_we,
  input  logic [sdfs_pkg::MAXCHG_W-1:0] cfg_wdata
);
  import sdfs_pkg::*;

  localparam int SUM_W  = SPEED_W + $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RING   = 3'd1;
  localparam logic [2:0] ST_AVG    = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DSTART = 3'd4;
  localparam logic [2:0] ST_DIST   = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0]              state;
  logic [MAXCHG_W-1:0]     max_change;
  speed_t                  last_filtered;
  speed_t                  filt;
  logic                    rej;
  logic                    div_neg;
  logic signed [PROD_W-1:0] prod;
  logic [SCALED_W-1:0]     scaled;
  logic [RECIP_PROD_W-1:0] recip_q;

  logic                    res_valid;
  dist_t                   res_dist;
  speed_t                  res_filt;
  logic                    res_rej;
  logic                    fin_load;

  logic                    accept;
  logic signed [SPEED_W:0] diff;
  logic signed [SPEED_W:0] lim;
  logic                    rejected_w;

  logic                    ring_upd;
  logic                    ring_done;
  logic signed [SUM_W-1:0] ring_sum;
  logic [FILL_W-1:0]       ring_fill;
  logic [SUM_W-1:0]        sum_mag;

  logic signed [FACTOR_W-1:0] factor;
  logic signed [PROD_W-1:0]   prod_w;
  logic [PROD_W-1:0]          adj_w;
  logic [QUOT_W-1:0]          quot;
  dist_t                      dist_w;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_change <= MAXCHG_RESET;
    end else if (cfg_we) begin
      max_change <= cfg_wdata;
    end
  end

  // Rate check against the last filtered speed
  assign accept       = speed.valid && speed.ready;
  assign speed.ready  = (state == ST_IDLE);
  assign diff         = (SPEED_W+1)'(speed.speed_sample) - (SPEED_W+1)'(last_filtered);
  assign lim          = $signed({2'b00, max_change});
  assign rejected_w   = (diff > lim) || (diff < -lim);
  assign ring_upd     = accept && !rejected_w;

  sdfs_ring #(.WINDOW(WINDOW)) u_ring (
    .clk    (clk),
    .rst    (rst),
    .upd    (ring_upd),
    .sample (speed.speed_sample),
    .done   (ring_done),
    .sum    (ring_sum),
    .fill   (ring_fill)
  );

  // Divider request: ring sum over fill count
  assign sum_mag  = ring_sum[SUM_W-1] ? SUM_W'(-ring_sum) : SUM_W'(ring_sum);

  always_comb begin
    div_req.start    = (state == ST_RING) && ring_done;
    div_req.dividend = {sum_mag, {(DIV_W - SUM_W){1'b0}}};
    div_req.divisor  = DIVISOR_W'(ring_fill);
    div_req.steps    = DIV_CNT_W'(SUM_W);
  end

  sdfs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // v * (LIN + v), one multiply registered before the divide
  assign factor = $signed(FACTOR_W'(DIST_LIN)) + FACTOR_W'(filt);
  assign prod_w = PROD_W'(filt) * PROD_W'(factor);

  // Numerator magnitude, biased by DEN-1 when negative so the quotient rounds to floor
  assign adj_w = prod[PROD_W-1] ? PROD_W'(PROD_W'(DIST_DEN - 1) - prod) : prod;

  // Quotient from the reciprocal product; negate for negative numerators
  assign quot   = recip_q[RECIP_PROD_W-1:RECIP_SH];
  assign dist_w = div_neg ? (DIST_W'(DIST_BASE) - DIST_W'(quot))
                          : (DIST_W'(DIST_BASE) + DIST_W'(quot));

  assign fin_load = (state == ST_FIN) && (!res_valid || result.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      last_filtered <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (fin_load) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= rejected_w ? ST_MUL : ST_RING;
          end
        end
        ST_RING: begin
          if (ring_done) begin
            state <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_rsp.done) begin
            last_filtered <= div_neg ? SPEED_W'(DIV_W'(0) - div_rsp.quotient)
                                     : div_rsp.quotient[SPEED_W-1:0];
            state         <= ST_MUL;
          end
        end
        ST_MUL:    state <= ST_DSTART;
        ST_DSTART: state <= ST_DIST;
        ST_DIST:   state <= ST_FIN;
        ST_FIN: begin
          if (fin_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rej  <= rejected_w;
      filt <= last_filtered;
    end
    if (state == ST_AVG && div_rsp.done) begin
      filt <= div_neg ? SPEED_W'(DIV_W'(0) - div_rsp.quotient)
                      : div_rsp.quotient[SPEED_W-1:0];
    end
    if (state == ST_RING && ring_done) begin
      div_neg <= ring_sum[SUM_W-1];
    end
    if (state == ST_MUL) begin
      prod <= prod_w;
    end
    // Drop the power-of-two part of the denominator
    if (state == ST_DSTART) begin
      div_neg <= prod[PROD_W-1];
      scaled  <= adj_w[MAG_W-1:DIST_SH];
    end
    // 21 x 22 bit reciprocal multiply for the remaining divide by 25
    if (state == ST_DIST) begin
      recip_q <= RECIP_PROD_W'(scaled) * RECIP_PROD_W'(RECIP);
    end
    if (fin_load) begin
      res_dist <= dist_w;
      res_filt <= filt;
      res_rej  <= rej;
    end
  end

  assign result.valid             = res_valid;
  assign result.distance_setpoint = res_dist;
  assign result.filtered_speed    = res_filt;
  assign result.sample_rejected   = res_rej;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst) accept |=> !speed.ready)
    else $error("second sample taken while one is in flight");

endmodule

/* verif/sdfs_checker.sv */
// Checker for the safety-distance block: watches the speed, result and config ports,
// predicts each result from a local copy of the filter state and compares field by field.
// Depends on sdfs_pkg, sdfs_in_if and sdfs_out_if.
module sdfs_checker (
  input  logic                          clk,
  input  logic                          rst,
  sdfs_in_if                            speed,
  sdfs_out_if                           result,
  input  logic                          cfg_we,
  input  logic [sdfs_pkg::MAXCHG_W-1:0] cfg_wdata,
  output int                            errors,
  output int                            pending,
  output sdfs_pkg::speed_t              last_speed
);
  timeunit 1ns;
  timeprecision 1ps;
  import sdfs_pkg::*;

  // averaging window and distance polynomial, Q8.8 in, Q16.8 out
  localparam int     RING_DEPTH = WINDOW_DEFAULT;
  localparam longint BASE_DIST  = 512;
  localparam longint LIN_COEF   = 55296;
  localparam longint DIST_DIV   = 51200;

  typedef struct packed {
    dist_t  distance;
    speed_t filtered;
    logic   rejected;
  } setpoint_t;

  speed_t                ring [RING_DEPTH];
  int                    slot;
  int                    fill;
  logic [MAXCHG_W-1:0]   max_chg;
  setpoint_t             setpoints_due [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Rate check, ring update, average and distance for one sample; updates state.
  function automatic setpoint_t filter_and_distance(speed_t sample);
    int        diff;
    int        lim;
    int        i;
    longint    total;
    longint    v;
    longint    num;
    longint    quot;
    setpoint_t r;
    diff       = int'(sample) - int'(last_speed);
    lim        = int'(max_chg);
    r.rejected = (diff > lim) || (diff < -lim);
    if (!r.rejected) begin
      ring[slot] = sample;
      slot       = (slot == RING_DEPTH - 1) ? 0 : slot + 1;
      if (fill < RING_DEPTH) fill++;
      // never-written entries are zero and still count in the sum
      total = 0;
      for (i = 0; i < RING_DEPTH; i++) total += ring[i];
      last_speed = speed_t'(total / fill);
    end
    v    = last_speed;
    num  = LIN_COEF * v + v * v;
    quot = num / DIST_DIV;
    // floor, not truncation, for negative numerators
    if ((num % DIST_DIV) != 0 && num < 0) quot -= 1;
    r.distance = dist_t'(BASE_DIST + quot);
    r.filtered = last_speed;
    return r;
  endfunction

  always @(posedge clk) begin
    setpoint_t want;
    if (rst) begin
      foreach (ring[i]) ring[i] = '0;
      slot       = 0;
      fill       = 0;
      last_speed = '0;
      max_chg    = MAXCHG_RESET;
      setpoints_due.delete();
      pending    = 0;
    end else begin
      // sample transfer: predict its result with the limit held before this edge
      if (speed.valid && speed.ready) begin
        setpoints_due.push_back(filter_and_distance(speed.speed_sample));
        pending++;
      end

      if (cfg_we) max_chg = cfg_wdata;

      // result transfer: compare with the oldest prediction
      if (result.valid && result.ready) begin
        if (setpoints_due.size() == 0) begin
          $error("result transfer with no sample outstanding");
          errors++;
        end else begin
          want = setpoints_due.pop_front();
          pending--;
          if (result.distance_setpoint !== want.distance) begin
            $error("distance_setpoint: expected %0d, got %0d",
                   want.distance, result.distance_setpoint);
            errors++;
          end
          if (result.filtered_speed !== want.filtered) begin
            $error("filtered_speed: expected %0d, got %0d",
                   want.filtered, result.filtered_speed);
            errors++;
          end
          if (result.sample_rejected !== want.rejected) begin
            $error("sample_rejected: expected %0d, got %0d",
                   want.rejected, result.sample_rejected);
            errors++;
          end
        end
      end
    end
  end

endmodule

/* verif/tb_safety_distance_from_filtered_speed.sv */
// Top of the safety-distance testbench: clock, reset, sample and config stimulus,
// result back-pressure and the verdict. Depends on sdfs_pkg, the channel interfaces,
// the block and sdfs_checker.
module tb_safety_distance_from_filtered_speed;
  timeunit 1ns;
  timeprecision 1ps;
  import sdfs_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 80;
  localparam int PHASE_ITEMS   = 325;
  localparam int NUM_PHASES    = 6;
  localparam int SPEED_MAX     = 32767;
  localparam int SPEED_MIN     = -32768;
  localparam int MAXCHG_MAX    = 32767;

  typedef enum int {ALWAYS_READY, HALF_READY, QUARTER_READY, PERIODIC_READY} stall_mode_e;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [MAXCHG_W-1:0] cfg_wdata;
  logic                hold_req;
  int                  errors;
  int                  pending;
  speed_t              last_speed;
  int                  cycle_count;
  int                  burst_left;
  int                  max_chg_now;

  sdfs_in_if  speed_ch ();
  sdfs_out_if result_ch ();

  safety_distance_from_filtered_speed uut (
    .clk       (clk),
    .rst       (rst),
    .speed     (speed_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sdfs_checker chk (
    .clk        (clk),
    .rst        (rst),
    .speed      (speed_ch),
    .result     (result_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .last_speed (last_speed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Sample near the current filtered speed, clamped to the Q8.8 range
  function automatic speed_t near_speed(int offset);
    int x;
    x = int'(last_speed) + offset;
    if (x > SPEED_MAX) x = SPEED_MAX;
    else if (x < SPEED_MIN) x = SPEED_MIN;
    return speed_t'(x);
  endfunction

  // One sample transfer, in bursts with random gaps; called and returns at a falling edge
  task automatic send_sample(input speed_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(2) == 0) ? 0 :
            ($urandom_range(3) == 0) ? int'($urandom_range(20, 70)) :
                                       int'($urandom_range(1, 6));
      if (gap > 0) begin
        speed_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    speed_ch.valid        <= 1'b1;
    speed_ch.speed_sample <= s;
    do @(posedge clk); while (!speed_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Register write once every result is back
  task automatic write_max_change(input int value);
    speed_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[MAXCHG_W-1:0];
    @(negedge clk);
    cfg_we      <= 1'b0;
    max_chg_now = value;
  endtask

  // Mostly samples that track the filtered speed, with some fully random ones
  task automatic send_random_sample();
    int span;
    int off;
    if ($urandom_range(3) == 0) begin
      send_sample(speed_t'($urandom));
    end else begin
      if ($urandom_range(7) == 0) begin
        off = ($urandom_range(1) == 1) ? max_chg_now : -max_chg_now;
      end else begin
        span = max_chg_now + max_chg_now / 4 + 2;
        off  = int'($urandom_range(2 * span)) - span;
      end
      send_sample(near_speed(off));
    end
  endtask

  // Result back-pressure: random segments of stall patterns, one long hold-off
  initial begin : receiver
    int          seg;
    int          period;
    int          k;
    bit          hold_done;
    stall_mode_e mode;
    result_ch.ready = 1'b0;
    hold_done       = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      seg    = $urandom_range(20, 200);
      mode   = stall_mode_e'($urandom_range(3));
      period = $urandom_range(2, 8);
      for (k = 0; k < seg; k++) begin
        case (mode)
          ALWAYS_READY:  result_ch.ready <= 1'b1;
          HALF_READY:    result_ch.ready <= ($urandom_range(1) == 1);
          QUARTER_READY: result_ch.ready <= ($urandom_range(3) == 0);
          default:       result_ch.ready <= ((k % period) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int phase;
    int n;
    int phase_max [NUM_PHASES];
    rst                   = 1'b1;
    speed_ch.valid        = 1'b0;
    speed_ch.speed_sample = '0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    hold_req              = 1'b0;
    burst_left            = 0;
    max_chg_now           = int'(MAXCHG_RESET);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limit: jumps of exactly the limit pass, one more fails, both directions
    send_sample(near_speed(0));
    send_sample(near_speed(max_chg_now));
    send_sample(near_speed(max_chg_now + 1));
    send_sample(near_speed(-max_chg_now - 1));
    send_sample(near_speed(-max_chg_now));
    send_sample(near_speed(0));
    send_sample(speed_t'(SPEED_MAX));
    send_sample(speed_t'(SPEED_MIN));

    // widest limit: top speed repeatedly, filling and wrapping the ring
    write_max_change(MAXCHG_MAX);
    repeat (11) send_sample(speed_t'(SPEED_MAX));
    send_sample(speed_t'(SPEED_MIN));

    // zero limit: only an unchanged speed passes
    write_max_change(0);
    send_sample(near_speed(0));
    send_sample(near_speed(1));
    send_sample(near_speed(-1));

    // random part, one limit setting per phase
    phase_max = '{0, MAXCHG_MAX, 1, 154, 0, 0};
    phase_max[4] = $urandom_range(MAXCHG_MAX);
    phase_max[5] = $urandom_range(2, 400);
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_max_change(phase_max[phase]);
      if (phase == 1) hold_req <= 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) send_random_sample();
    end

    // drain
    speed_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
